// ===== src/assert_macros.svh =====
// assertion macros used by the decoder core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every enabled clock edge
`define LZWC_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define LZWC_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lzwc_pkg.sv =====
// shared constants and types for the window copy decoder
package lzwc_pkg;

    localparam int WINDOW_SIZE = 32768;
    localparam int MAX_MATCH   = 64;

    localparam int PTR_W  = $clog2(WINDOW_SIZE);
    localparam int CNT_W  = 16;
    localparam int DIST_W = 16;
    localparam int LEN_W  = 7;
    localparam int BYTE_W = 8;

    localparam logic OP_LITERAL = 1'b0;
    localparam logic OP_MATCH   = 1'b1;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== src/lzwc_window_ram.sv =====
// history window memory, one write port and one registered read port
module lzwc_window_ram
    import lzwc_pkg::*;
(
    input  logic  clk,
    input  logic  we,
    input  ptr_t  waddr,
    input  byte_t wdata,
    input  logic  re,
    input  ptr_t  raddr,
    output byte_t rdata
);

    byte_t mem [WINDOW_SIZE];
    byte_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lz_window_copy_decoder_core.sv =====
// Window copy decoder: a literal token gives its byte. A match token of length n (saturated
// to 64) is accepted, then the window memory is read for its first byte, then one byte per
// cycle follows while out_stall does not hold a byte, set by the single read port of the
// 32 KiB window. A zero-length match gives nothing; a nonzero-length match with a bad
// distance, or any token after a halt, gives one error transfer. One token is worked on at
// a time; a new token is taken only when the result register is empty or its transfer
// completes in that cycle, so a byte held by out_stall also holds back the copy. The window
// needs no clearing after reset since a match never reaches bytes that were not written.
`include "assert_macros.svh"

module lz_window_copy_decoder_core
    import lzwc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [BYTE_W-1:0] literal_byte,
    input  logic [DIST_W-1:0] distance,
    input  logic [LEN_W-1:0]  copy_length,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last,
    output logic              error
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic              halted_reg, halted_next;
    ptr_t              wp_reg, wp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    ptr_t              src_reg, src_next;
    logic [LEN_W-1:0]  rd_left_reg, rd_left_next;
    logic [LEN_W-1:0]  em_left_reg, em_left_next;
    logic              q_valid_reg, q_valid_next;
    logic              fwd_reg, fwd_next;
    byte_t             fwd_data_reg, fwd_data_next;

    logic              out_valid_reg, out_valid_next;
    byte_t             out_byte_reg, out_byte_next;
    logic              last_reg, last_next;
    logic              error_reg, error_next;

    logic              out_free;
    logic              accept;
    logic              emit;
    logic              issue;
    logic [LEN_W-1:0]  len_sat;
    logic              bad_dist;
    byte_t             copy_byte;

    logic              ram_we;
    ptr_t              ram_waddr;
    byte_t             ram_wdata;
    byte_t             ram_rdata;

    lzwc_window_ram u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (issue),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !((state_reg == ST_IDLE) && out_free);
    assign accept    = in_valid && !in_stall;
    assign emit      = (state_reg == ST_COPY) && q_valid_reg && out_free;
    assign issue     = (state_reg == ST_COPY) && (rd_left_reg != '0) && (!q_valid_reg || emit);
    assign len_sat   = (copy_length > LEN_W'(MAX_MATCH)) ? LEN_W'(MAX_MATCH) : copy_length;
    assign bad_dist  = (distance == '0) || (distance > count_reg);
    // distance of one reads the byte written in the same cycle
    assign copy_byte = fwd_reg ? fwd_data_reg : ram_rdata;

    always_comb
    begin
        state_next     = state_reg;
        halted_next    = halted_reg;
        src_next       = src_reg;
        rd_left_next   = rd_left_reg;
        em_left_next   = em_left_reg;
        q_valid_next   = q_valid_reg;
        fwd_next       = fwd_reg;
        fwd_data_next  = fwd_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        error_next     = error_reg;
        ram_we         = 1'b0;
        ram_waddr      = wp_reg;
        ram_wdata      = literal_byte;

        if (accept)
        begin
            if (halted_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = '0;
                last_next      = 1'b1;
                error_next     = 1'b1;
            end
            else if (opcode == OP_LITERAL)
            begin
                ram_we         = 1'b1;
                ram_wdata      = literal_byte;
                out_valid_next = 1'b1;
                out_byte_next  = literal_byte;
                last_next      = 1'b1;
                error_next     = 1'b0;
            end
            else if (len_sat == '0)
            begin
                // zero length match leaves everything as is
            end
            else if (bad_dist)
            begin
                halted_next    = 1'b1;
                out_valid_next = 1'b1;
                out_byte_next  = '0;
                last_next      = 1'b1;
                error_next     = 1'b1;
            end
            else
            begin
                src_next     = wp_reg - distance[PTR_W-1:0];
                rd_left_next = len_sat;
                em_left_next = len_sat;
                state_next   = ST_COPY;
            end
        end

        if (emit)
        begin
            ram_we         = 1'b1;
            ram_wdata      = copy_byte;
            out_valid_next = 1'b1;
            out_byte_next  = copy_byte;
            last_next      = (em_left_reg == LEN_W'(1));
            error_next     = 1'b0;
            em_left_next   = em_left_reg - LEN_W'(1);
            if (em_left_reg == LEN_W'(1))
            begin
                state_next = ST_IDLE;
            end
        end

        if (issue)
        begin
            src_next      = src_reg + PTR_W'(1);
            rd_left_next  = rd_left_reg - LEN_W'(1);
            fwd_next      = ram_we && (ram_waddr == src_reg);
            fwd_data_next = ram_wdata;
            q_valid_next  = 1'b1;
        end
        else if (emit)
        begin
            q_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        wp_next    = wp_reg;
        count_next = count_reg;
        if (ram_we)
        begin
            wp_next = wp_reg + PTR_W'(1);
            if (count_reg != CNT_W'(WINDOW_SIZE))
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            halted_reg    <= 1'b0;
            wp_reg        <= '0;
            count_reg     <= '0;
            rd_left_reg   <= '0;
            em_left_reg   <= '0;
            q_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            halted_reg    <= halted_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            rd_left_reg   <= rd_left_next;
            em_left_reg   <= em_left_next;
            q_valid_reg   <= q_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        fwd_reg      <= fwd_next;
        fwd_data_reg <= fwd_data_next;
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
        error_reg    <= error_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;
    assign error     = error_reg;

    `LZWC_ASSERT(a_qvalid_in_copy, clk, rst_n, !q_valid_reg || (state_reg == ST_COPY), "window data pending outside a copy")
    `LZWC_ASSERT_NEXT(a_halt_sticky, clk, rst_n, halted_reg, halted_reg, "halt cleared without reset")
    `LZWC_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(WINDOW_SIZE), "byte count above window size")
    `LZWC_ASSERT(a_reads_lead, clk, rst_n, (state_reg != ST_COPY) || (em_left_reg >= rd_left_reg), "more reads left than bytes to emit")

endmodule
